[rtl/pva_pkg.sv]
// Package for the pointer velocity acceleration block.
// Request/result payload types, controller/datapath command and status
// structs, register indexes and arithmetic constants. No dependencies.
package pva_pkg;

  // Payload types
  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [63:0]        time_us;
  } motion_t;

  typedef struct packed {
    logic [23:0] sensitivity;
    logic [30:0] velocity_px_per_sec;
  } result_t;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SENS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SENS  = 8'd3;

  localparam logic [23:0] BASE_SENS_RESET = 24'd88473;
  localparam logic [23:0] THRESHOLD_RESET = 24'd35;
  localparam logic [23:0] GAIN_RESET      = 24'd45875;
  localparam logic [23:0] MAX_SENS_RESET  = 24'd249036;

  // Arithmetic constants
  localparam logic [18:0] GAP_LIMIT_US = 19'd500000;
  localparam logic [19:0] US_PER_SEC   = 20'd1000000;

  // Iteration counts of the square root unit and the shared divider
  localparam int CNT_W          = 6;
  localparam int ROOT_STEPS     = 16;
  localparam int VEL_DIV_STEPS  = 36;
  localparam int SENS_DIV_STEPS = 55;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture request, swap timestamp history
    logic check;      // gap check, squares
    logic root_init;  // load square root unit
    logic root_step;  // one square root iteration
    logic scale;      // distance * 1e6, load divider
    logic div_step;   // one divider iteration
    logic curve;      // saturate velocity, threshold compare
    logic gain;       // excess * gain, load divider
    logic finish;     // write result register
  } pva_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic skip;       // no usable time history
    logic above;      // velocity above a nonzero threshold
    logic out_free;   // result register can take a new result
  } pva_status_t;

endpackage

[rtl/pointer_velocity_acceleration.sv]
// Top level of the pointer velocity acceleration block.
// Joins pva_ctrl and pva_datapath; types and constants from pva_pkg.
//
// Takes one pointer motion request (signed deltas and a microsecond
// timestamp) and returns one result: the 8.16 sensitivity multiplier and
// the measured speed in px/s, saturated to 31 bits. The block keeps the
// previous timestamp (cleared by reset, meaning no history) and replaces it
// with every request. With no history, a timestamp that does not advance,
// or a gap above 500 ms, the result is base sensitivity and speed 0.
// Otherwise speed = floor(sqrt(dx^2+dy^2)) * 1e6 / gap; above a nonzero
// threshold, sensitivity = base + excess*gain/threshold, clamped to
// max_sensitivity. One request is in work at a time. The work runs through
// the 16-step square root and the one-bit-per-cycle restoring divider, used
// for 36 steps to get the speed and 55 steps to scale the excess; a failed
// gap check skips both, and a speed at or below the threshold skips the
// second divide. motion_stall drops the cycle after the result is written,
// even while that result still waits on result_stall. Registers are written
// through cfg_* while the block is idle; the block does not enforce this,
// the user is bound to it. cfg_ready is always high and indexes past 3 are
// dropped.
module pointer_velocity_acceleration (
  input  logic                             clk,
  input  logic                             rst,
  // motion requests
  input  logic                             motion_valid,
  output logic                             motion_stall,
  input  pva_pkg::motion_t                 motion,
  // results
  output logic                             result_valid,
  input  logic                             result_stall,
  output pva_pkg::result_t                 result,
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pva_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pva_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pva_pkg::pva_cmd_t    cmd;
  pva_pkg::pva_status_t status;

  // register port never back-pressures
  assign cfg_ready = 1'b1;

  pva_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .motion_valid (motion_valid),
    .motion_stall (motion_stall),
    .status       (status),
    .cmd          (cmd)
  );

  pva_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .motion       (motion),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[rtl/pva_ctrl.sv]
// Sequencing controller for the pointer velocity acceleration block.
// Drives pva_datapath through pva_pkg::pva_cmd_t; uses pva_pkg.
module pva_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 motion_valid,
  output logic                 motion_stall,
  input  pva_pkg::pva_status_t status,
  output pva_pkg::pva_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_ROOT_INIT = 4'd2;
  localparam logic [3:0] S_ROOT      = 4'd3;
  localparam logic [3:0] S_SCALE     = 4'd4;
  localparam logic [3:0] S_DIV_VEL   = 4'd5;
  localparam logic [3:0] S_CURVE     = 4'd6;
  localparam logic [3:0] S_GAIN      = 4'd7;
  localparam logic [3:0] S_DIV_SENS  = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  logic [3:0]                 state, state_next;
  logic [pva_pkg::CNT_W-1:0]  cnt, cnt_next;

  assign motion_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (motion_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        cnt_next      = pva_pkg::CNT_W'(pva_pkg::ROOT_STEPS - 1);
        state_next    = status.skip ? S_FINISH : S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        cnt_next   = pva_pkg::CNT_W'(pva_pkg::VEL_DIV_STEPS - 1);
        state_next = S_DIV_VEL;
      end
      S_DIV_VEL: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_CURVE;
        end
      end
      S_CURVE: begin
        cmd.curve  = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        cnt_next   = pva_pkg::CNT_W'(pva_pkg::SENS_DIV_STEPS - 1);
        state_next = status.above ? S_DIV_SENS : S_FINISH;
      end
      S_DIV_SENS: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[rtl/pva_datapath.sv]
// Datapath of the pointer velocity acceleration block: registers, history,
// square root unit, shared restoring divider, curve and result register.
// Uses pva_pkg; sequenced by pva_ctrl.
module pva_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pva_pkg::motion_t                     motion,
  input  logic                                 cfg_valid,
  input  logic [pva_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pva_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output pva_pkg::result_t                     result,
  input  pva_pkg::pva_cmd_t                    cmd,
  output pva_pkg::pva_status_t                 status
);

  // Configuration registers
  logic [23:0] base_sens, threshold, gain, max_sens;

  // Request and history
  logic [63:0]        prev_time;
  logic signed [15:0] dx_r, dy_r;
  logic [63:0]        now_r, last_r;

  // Gap check and squares
  logic        skip_r;
  logic [18:0] gap_r;
  logic [31:0] sqx, sqy;

  // Square root unit
  logic [31:0] rad, root, rbit;

  // Divider: dividend/quotient shift register, remainder, divisor
  logic [55:0] dq;
  logic [23:0] dr, dvsr;

  // Curve
  logic [30:0] vel_r, excess_r;
  logic        above_r;

  logic        result_valid_r;
  pva_pkg::result_t result_r;

  // Combinational helpers
  logic [64:0]        diff;
  logic signed [31:0] sq_x_full, sq_y_full;
  logic [31:0]        root_trial;
  logic [35:0]        scaled;
  logic [24:0]        div_shift;
  logic               div_ge;
  logic [30:0]        vel_sat;
  logic [54:0]        gain_prod;
  logic [54:0]        sens_quo;
  logic [24:0]        sens_sum;
  logic [23:0]        sens_accel;
  pva_pkg::result_t   result_next;

  always_comb begin
    diff       = {1'b0, now_r} - {1'b0, last_r};
    sq_x_full  = 32'(dx_r) * 32'(dx_r);
    sq_y_full  = 32'(dy_r) * 32'(dy_r);
    root_trial = root + rbit;
    scaled     = {20'b0, root[15:0]} * {16'b0, pva_pkg::US_PER_SEC};
    div_shift  = {dr, dq[55]};
    div_ge     = (div_shift >= {1'b0, dvsr});
    vel_sat    = (dq[35:31] != '0) ? '1 : dq[30:0];
    gain_prod  = {24'b0, excess_r} * {31'b0, gain};
    sens_quo   = dq[54:0];
    sens_sum   = {1'b0, base_sens} + {1'b0, sens_quo[23:0]};
    if (sens_quo[54:24] != '0 || sens_sum > {1'b0, max_sens}) begin
      sens_accel = max_sens;
    end else begin
      sens_accel = sens_sum[23:0];
    end
    if (skip_r) begin
      result_next.sensitivity         = base_sens;
      result_next.velocity_px_per_sec = '0;
    end else if (!above_r) begin
      result_next.sensitivity         = base_sens;
      result_next.velocity_px_per_sec = vel_r;
    end else begin
      result_next.sensitivity         = sens_accel;
      result_next.velocity_px_per_sec = vel_r;
    end
  end

  // Configuration writes and history (control state)
  always_ff @(posedge clk) begin
    if (rst) begin
      base_sens <= pva_pkg::BASE_SENS_RESET;
      threshold <= pva_pkg::THRESHOLD_RESET;
      gain      <= pva_pkg::GAIN_RESET;
      max_sens  <= pva_pkg::MAX_SENS_RESET;
      prev_time <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pva_pkg::CFG_BASE_SENS: base_sens <= cfg_data;
          pva_pkg::CFG_THRESHOLD: threshold <= cfg_data;
          pva_pkg::CFG_GAIN:      gain      <= cfg_data;
          pva_pkg::CFG_MAX_SENS:  max_sens  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        prev_time <= motion.time_us;
      end
    end
  end

  // Arithmetic (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= motion.delta_x;
      dy_r   <= motion.delta_y;
      now_r  <= motion.time_us;
      last_r <= prev_time;
    end
    if (cmd.check) begin
      skip_r <= (last_r == '0) || diff[64] || (diff[63:0] == '0) ||
                (diff[63:0] > {45'b0, pva_pkg::GAP_LIMIT_US});
      gap_r  <= diff[18:0];
      sqx    <= unsigned'(sq_x_full);
      sqy    <= unsigned'(sq_y_full);
    end
    if (cmd.root_init) begin
      rad  <= sqx + sqy;
      root <= '0;
      rbit <= 32'h4000_0000;
    end
    if (cmd.root_step) begin
      if (rad >= root_trial) begin
        rad  <= rad - root_trial;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.scale) begin
      // left-align the 36-bit dividend for a 36-step divide
      dq   <= {scaled, 20'b0};
      dr   <= '0;
      dvsr <= {5'b0, gap_r};
    end
    if (cmd.div_step) begin
      dr <= div_ge ? 24'(div_shift - {1'b0, dvsr}) : div_shift[23:0];
      dq <= {dq[54:0], div_ge};
    end
    if (cmd.curve) begin
      vel_r    <= vel_sat;
      above_r  <= (threshold != '0) && (vel_sat > {7'b0, threshold});
      excess_r <= vel_sat - {7'b0, threshold};
    end
    if (cmd.gain) begin
      // left-align the 55-bit product for a 55-step divide
      dq   <= {gain_prod, 1'b0};
      dr   <= '0;
      dvsr <= threshold;
    end
    if (cmd.finish) begin
      result_r <= result_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      result_valid_r <= 1'b1;
    end else if (!result_stall) begin
      result_valid_r <= 1'b0;
    end
  end

  assign result_valid    = result_valid_r;
  assign result          = result_r;
  assign status.skip     = skip_r;
  assign status.above    = above_r;
  assign status.out_free = !result_valid_r || !result_stall;

endmodule

[rtl/pva_checker.sv]
// Port-level checker for pointer_velocity_acceleration, with its bind.
// Uses pva_pkg result type only.
module pva_checker (
  input logic             clk,
  input logic             rst,
  input logic             motion_valid,
  input logic             motion_stall,
  input logic             result_valid,
  input logic             result_stall,
  input pva_pkg::result_t result
);

  // stalled result stays offered
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    motion_valid && !motion_stall |=> motion_stall)
    else $error("second request taken while busy");

  // no result can follow a request in the very next cycle
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(motion_valid && !motion_stall))
    else $error("result appeared too early");

endmodule

bind pointer_velocity_acceleration pva_checker u_pva_checker (
  .clk          (clk),
  .rst          (rst),
  .motion_valid (motion_valid),
  .motion_stall (motion_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[dv/pointer_velocity_acceleration_tb.sv]
// Self-checking testbench for pointer_velocity_acceleration.
// Drives motion requests and register writes, predicts each result in-line
// and compares it against the block output. Depends on pva_pkg and the RTL.
`timescale 1ns / 100ps

module pointer_velocity_acceleration_tb;
  import pva_pkg::*;

  localparam int          LIMIT_CYCLES        = 1_500_000;
  localparam int          TAIL_CYCLES         = 130;    // longer than the boost path to a result
  localparam int          MAX_SHOWN           = 10;
  localparam int          REPORTS_PER_SETTING = 250;
  localparam logic [63:0] GAP_LIMIT           = 64'd500000;
  localparam logic [63:0] MICROS_PER_SEC      = 64'd1000000;
  localparam logic [63:0] SPEED_MAX           = 64'h7FFF_FFFF;
  localparam logic [23:0] FULL24              = 24'hFF_FFFF;

  // register indexes the block must drop
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  logic                   clk;
  logic                   rst;
  logic                   motion_valid;
  logic                   motion_stall;
  motion_t                motion;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pointer_velocity_acceleration uut (
    .clk          (clk),
    .rst          (rst),
    .motion_valid (motion_valid),
    .motion_stall (motion_stall),
    .motion       (motion),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the curve registers and of the timestamp history.
  logic [23:0] curve_base      = BASE_SENS_RESET;
  logic [23:0] curve_threshold = THRESHOLD_RESET;
  logic [23:0] curve_gain      = GAIN_RESET;
  logic [23:0] curve_max       = MAX_SENS_RESET;
  logic [63:0] last_stamp_us   = '0;

  // Results still owed by the block, oldest first.
  result_t     owed_results[$];

  // Stimulus timeline; the next report time is derived from this.
  logic [63:0] stamp_us;
  bit          steady;        // sender sends back to back while set

  int          error_count;
  int          requests_sent;
  int          results_seen;
  int          reg_writes;
  int          curve_settings;
  int          n_no_history;
  int          n_flat;
  int          n_boost;
  int          n_clamped;
  int          cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // floor(sqrt(n)); the squared deltas stay below 2^31 so 16 root bits do.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n)
        root = trial;
    end
    return root;
  endfunction

  // Expected result for one accepted motion request. Also advances the
  // timestamp history, since the block replaces it on every request.
  function automatic result_t sensitivity_for(input motion_t m);
    longint      dx;
    longint      dy;
    logic [63:0] prior;
    logic [63:0] gap;
    logic [63:0] distance;
    logic [63:0] speed;
    logic [63:0] sens;
    result_t     r;
    prior         = last_stamp_us;
    last_stamp_us = m.time_us;
    // no history, stale or out-of-order time, or too long since last report
    if (prior == 0 || m.time_us <= prior || m.time_us - prior > GAP_LIMIT) begin
      n_no_history++;
      r.sensitivity         = curve_base;
      r.velocity_px_per_sec = '0;
      return r;
    end
    gap      = m.time_us - prior;
    dx       = longint'($signed(m.delta_x));
    dy       = longint'($signed(m.delta_y));
    distance = floor_root(64'(dx * dx + dy * dy));
    speed    = distance * MICROS_PER_SEC / gap;
    if (speed > SPEED_MAX)
      speed = SPEED_MAX;
    if (curve_threshold == 0 || speed <= 64'(curve_threshold)) begin
      n_flat++;
      sens = 64'(curve_base);
    end else begin
      n_boost++;
      sens = 64'(curve_base)
           + (speed - 64'(curve_threshold)) * 64'(curve_gain) / 64'(curve_threshold);
      if (sens > 64'(curve_max)) begin
        n_clamped++;
        sens = 64'(curve_max);
      end
    end
    r.sensitivity         = sens[23:0];
    r.velocity_px_per_sec = speed[30:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Outputs are read right after the edge, so they hold pre-edge values.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        flag_error($sformatf("result %0d with no request pending: sens %0d speed %0d",
                             results_seen, result.sensitivity,
                             result.velocity_px_per_sec));
      end else begin
        want = owed_results.pop_front();
        if (result.sensitivity !== want.sensitivity)
          flag_error($sformatf("result %0d sensitivity: expected %0d, got %0d",
                               results_seen, want.sensitivity, result.sensitivity));
        if (result.velocity_px_per_sec !== want.velocity_px_per_sec)
          flag_error($sformatf("result %0d speed: expected %0d, got %0d",
                               results_seen, want.velocity_px_per_sec,
                               result.velocity_px_per_sec));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Idling and back-pressure
  // ---------------------------------------------------------------------

  // Mostly none or short, now and then a long one.
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result stall: open stretches (some long) between stall bursts.
  initial begin : result_backpressure
    int open_run;
    result_stall <= 1'b0;
    forever begin
      open_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(1, 30);
      repeat (open_run) @(posedge clk);
      result_stall <= 1'b1;
      repeat (1 + pick_idle()) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pointer_velocity_acceleration_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // One motion request. Valid stays high after acceptance so a follow-on
  // request with no gap goes out without a dip; a gap lowers it first.
  task automatic send_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic [63:0] t);
    int      gap;
    motion_t m;
    m.delta_x = dx;
    m.delta_y = dy;
    m.time_us = t;
    gap = steady ? 0 : pick_idle();
    if (gap > 0) begin
      motion_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    motion_valid <= 1'b1;
    motion       <= m;
    do @(posedge clk); while (motion_stall);
    owed_results.push_back(sensitivity_for(m));
    requests_sent++;
  endtask

  // Drop valid and wait until every owed result is back; the block is
  // then idle, since each request yields exactly one result.
  task automatic drain_results();
    motion_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  // One register write; valid is left high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_BASE_SENS: curve_base      = val;
      CFG_THRESHOLD: curve_threshold = val;
      CFG_GAIN:      curve_gain      = val;
      CFG_MAX_SENS:  curve_max       = val;
      default: ;
    endcase
  endtask

  // Load a whole curve while idle.
  task automatic apply_curve(input logic [23:0] base, input logic [23:0] thr,
                             input logic [23:0] gain, input logic [23:0] top);
    drain_results();
    write_reg(CFG_BASE_SENS, base);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_MAX_SENS, top);
    cfg_valid <= 1'b0;
    curve_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Random request content
  // ---------------------------------------------------------------------

  // Deltas spread over all magnitudes, with the rails and zero now and then.
  function automatic logic signed [15:0] rand_delta();
    int          roll;
    logic [15:0] mag;
    roll = $urandom_range(0, 99);
    if (roll < 10)
      mag = 16'd32767;
    else if (roll < 18)
      mag = '0;
    else
      mag = 16'($urandom) & 16'((32'd1 << $urandom_range(1, 15)) - 1);
    return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
  endfunction

  // Mostly well-formed reports inside the gap window so the speed and the
  // curve get exercised; the rest breaks the timestamp history.
  task automatic random_reports(input int count);
    int          roll;
    logic [63:0] gap;
    logic [63:0] t;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0)
        steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        gap = 64'd1 + (64'($urandom) & ((64'd1 << $urandom_range(0, 19)) - 1));
        if (gap > GAP_LIMIT)
          gap = GAP_LIMIT;
        stamp_us = stamp_us + gap;
      end else if (roll < 87) begin
        stamp_us = stamp_us + GAP_LIMIT + 64'd1 + 64'($urandom_range(0, 5_000_000));
      end else if (roll < 91) begin
        // repeated timestamp
      end else if (roll < 95) begin
        stamp_us = stamp_us - 64'($urandom_range(1, 1_000_000));
      end else if (roll < 98) begin
        stamp_us = {$urandom, $urandom};
      end
      t = (roll >= 98) ? 64'd0 : stamp_us;   // a report with no valid time
      send_report(rand_delta(), rand_delta(), t);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Timestamp history under the reset curve: first report, repeats,
  // backward and zero time, gap at and past the limit, 64-bit wrap.
  task automatic test_time_history();
    send_report(16'sd3, 16'sd4, 64'd1000);          // no history yet
    send_report(16'sd3, 16'sd4, 64'd1000);          // time did not advance
    send_report(16'sd3, 16'sd4, 64'd900);           // time went backward
    send_report(16'sd3, 16'sd4, 64'd0);             // no valid time
    send_report(16'sd3, 16'sd4, 64'd5000);          // history cleared by the zero
    send_report(16'sd7, 16'sd0, 64'd205000);        // speed exactly at threshold
    send_report(16'sd32767, -16'sd32767, 64'd705000);   // gap right at the limit
    send_report(-16'sd32767, 16'sd32767, 64'd1205001);  // one past the limit
    send_report(-16'sd32767, -16'sd32767, 64'd1205002); // 1 us gap: speed saturates
    send_report(16'sd0, 16'sd0, 64'd1205010);       // no motion
    send_report(16'sd1, -16'sd1, 64'd1225010);      // just above threshold
    send_report(16'sd100, 16'sd0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_report(16'sd100, 16'sd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_report(16'sd5, 16'sd5, 64'd2);             // timestamp wrapped
  endtask

  // Writes to indexes past the curve registers must change nothing.
  task automatic test_unused_index();
    drain_results();
    write_reg(CFG_UNUSED_LO, 24'($urandom));
    write_reg(CFG_UNUSED_HI, 24'($urandom));
    cfg_valid <= 1'b0;
    send_report(16'sd9, 16'sd12, 64'd10_000);
    send_report(16'sd30, -16'sd40, 64'd12_000);
  endtask

  // Curve corners: threshold off, max below base, all-ones and all-zero.
  task automatic test_curve_corners();
    apply_curve(BASE_SENS_RESET, '0, GAIN_RESET, MAX_SENS_RESET);
    send_report(16'sd3000, 16'sd4000, 64'd13_000);  // fast, but curve disabled

    apply_curve(24'd200000, 24'd10, 24'd65536, 24'd100000);
    send_report(16'sd0, 16'sd1, 64'd213_000);       // slow: base, above max
    send_report(16'sd50, 16'sd0, 64'd214_000);      // fast: clamped below base

    apply_curve(FULL24, FULL24, FULL24, FULL24);
    send_report(-16'sd32767, 16'sd1, 64'd214_001);
    send_report(16'sd1, 16'sd0, 64'd215_000);

    apply_curve('0, '0, '0, '0);
    send_report(16'sd32767, 16'sd32767, 64'd215_001);
  endtask

  // Random traffic over several curve settings, extremes included.
  task automatic test_random_curves();
    logic [23:0] base;
    stamp_us = 64'd1_000_000;
    apply_curve(BASE_SENS_RESET, THRESHOLD_RESET, GAIN_RESET, MAX_SENS_RESET);
    random_reports(REPORTS_PER_SETTING);
    apply_curve(FULL24, FULL24, FULL24, FULL24);
    random_reports(REPORTS_PER_SETTING);
    apply_curve('0, '0, '0, '0);
    random_reports(REPORTS_PER_SETTING);
    apply_curve(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    random_reports(REPORTS_PER_SETTING);
    // small threshold with max under base
    base = 24'($urandom_range(65536, 1_000_000));
    apply_curve(base, 24'($urandom_range(1, 50)), 24'($urandom),
                base - 24'($urandom_range(1, 60000)));
    random_reports(REPORTS_PER_SETTING);
    apply_curve(24'($urandom_range(0, 200000)), 24'($urandom_range(1, 200)),
                24'($urandom_range(0, 200000)), 24'($urandom_range(100000, 2_000_000)));
    random_reports(REPORTS_PER_SETTING);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin : run
    rst          <= 1'b1;
    motion_valid <= 1'b0;
    motion       <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    steady        = 1'b0;
    stamp_us      = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_time_history();
    test_unused_index();
    test_curve_corners();
    test_random_curves();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);   // catch any stray extra result

    $display("covered %0d requests: %0d no history, %0d at base, %0d boosted (%0d clamped)",
             requests_sent, n_no_history, n_flat, n_boost, n_clamped);
    $display("%0d register writes over %0d curve settings, %0d results checked",
             reg_writes, curve_settings, results_seen);
    if (error_count == 0) begin
      $display("pointer_velocity_acceleration_tb: clean");
    end else begin
      $display("pointer_velocity_acceleration_tb: errors");
    end
    $finish;
  end

endmodule
